>>> src/assert_macros.svh
// Assertion helpers shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FBEC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define FBEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FBEC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FBEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> src/fbec_pkg.sv
// ----------------------------------------------------------------------------
// fbec_pkg
// Types and codes shared by the free-bitmap extent checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fbec_pkg;

	// input item actions
	localparam logic [1:0] ACT_HEADER  = 2'd0;
	localparam logic [1:0] ACT_CHUNK   = 2'd1;
	localparam logic [1:0] ACT_END     = 2'd2;
	localparam logic [1:0] ACT_FOREIGN = 2'd3;

	// summary break reasons
	localparam logic [1:0] RSN_NORMAL     = 2'd0;
	localparam logic [1:0] RSN_FOREIGN    = 2'd1;
	localparam logic [1:0] RSN_START_PAST = 2'd2;
	localparam logic [1:0] RSN_END_PAST   = 2'd3;

	// result kinds
	localparam logic KIND_EXTENT  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_GROUP_START  = 2'd0;
	localparam logic [1:0] REG_GROUP_LENGTH = 2'd1;
	localparam logic [1:0] REG_SECTOR_SHIFT = 2'd2;
	localparam logic [1:0] REG_EXP_EXTENTS  = 2'd3;

	localparam logic [4:0] SECTOR_SHIFT_RST = 5'd12;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CPREP,
		S_CSCAN,
		S_GPREP,
		S_GDECIDE,
		S_FEXT,
		S_FSUM
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;       // latch input item
		logic prep_chunk;   // build edge vector
		logic prep_group;   // group end and record end sums
		logic scan_step;    // retire lowest edge
		logic chunk_done;   // advance scan address, keep last bit
		logic hdr_load;     // header accepted: scan address = record start
		logic emit_ext_fin; // close open run at group end
		logic emit_sum;     // summary, then rearm
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] act;
		logic       trans_any;
		logic       cur_is_fall;
		logic       start_bad;
		logic       end_bad;
		logic       carry_bit;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> src/free_bitmap_to_extents_checker.sv
// ----------------------------------------------------------------------------
// free_bitmap_to_extents_checker
// Free-space bitmap to free-extent converter with group bounds and
// extent-count check.
// ----------------------------------------------------------------------------
// A chunk item is latched, then its run edges (set/clear changes, first bit
// against the carried bit) among its valid bits, at most CHUNK_BITS, are
// built; a priority encoder retires the lowest edge each cycle unless a
// falling edge waits for room; a falling edge also loads the output register.
// Header, end and foreign items pass a prep and a decide state. The output
// register decouples the result side: the next item is taken while a result
// is still waiting, and work stalls only when a new result meets a full
// register. No clearing pass after reset.
`default_nettype none

module free_bitmap_to_extents_checker import fbec_pkg::*; #(
	parameter int CHUNK_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] record_start,
	input  wire logic [63:0] record_length,
	input  wire logic [63:0] chunk_bits,
	input  wire logic [6:0]  chunk_bit_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [63:0]      extent_base,
	output logic [63:0]      extent_end,
	output logic [1:0]       break_reason,
	output logic             count_mismatch,
	output logic [31:0]      extents_found,
	output logic             last
);

	cmd_t cmd;
	sts_t sts;

	fbec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbec_dp #(
		.CHUNK_BITS (CHUNK_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.action          (action),
		.record_start    (record_start),
		.record_length   (record_length),
		.chunk_bits      (chunk_bits),
		.chunk_bit_count (chunk_bit_count),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.extent_base     (extent_base),
		.extent_end      (extent_end),
		.break_reason    (break_reason),
		.count_mismatch  (count_mismatch),
		.extents_found   (extents_found),
		.last            (last)
	);

endmodule

`default_nettype wire

>>> src/fbec_ctrl.sv
// ----------------------------------------------------------------------------
// fbec_ctrl
// Sequencer: accepts items, walks run edges one a cycle while no falling edge
// waits for output room, orders the results of a group close.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fbec_ctrl import fbec_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire sts_t       sts,
	output cmd_t            cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (action == ACT_CHUNK) ? S_CPREP : S_GPREP;
				end
			end
			S_CPREP: state_d = S_CSCAN;
			S_CSCAN: begin
				if (!sts.trans_any) begin
					state_d = S_IDLE;
				end
			end
			S_GPREP: state_d = S_GDECIDE;
			S_GDECIDE: begin
				if (sts.act == ACT_HEADER && !sts.start_bad && !sts.end_bad) begin
					state_d = S_IDLE;
				end else if (sts.carry_bit) begin
					state_d = S_FEXT;
				end else begin
					state_d = S_FSUM;
				end
			end
			S_FEXT: begin
				if (sts.out_free) begin
					state_d = S_FSUM;
				end
			end
			S_FSUM: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_CPREP: cmd.prep_chunk = 1'b1;
			S_CSCAN: begin
				if (!sts.trans_any) begin
					cmd.chunk_done = 1'b1;
				end else if (!sts.cur_is_fall || sts.out_free) begin
					// a falling edge waits for room in the output register
					cmd.scan_step = 1'b1;
				end
			end
			S_GPREP: cmd.prep_group = 1'b1;
			S_GDECIDE: begin
				if (sts.act == ACT_HEADER && !sts.start_bad && !sts.end_bad) begin
					cmd.hdr_load = 1'b1;
				end
			end
			S_FEXT: cmd.emit_ext_fin = sts.out_free;
			S_FSUM: cmd.emit_sum     = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`FBEC_ASSERT_NEXT(a_scan_ends_idle, clk, arst_n, state_q == S_CSCAN && !sts.trans_any, state_q == S_IDLE)
	`FBEC_ASSERT_IMP(a_emit_has_room, clk, arst_n, cmd.emit_ext_fin || cmd.emit_sum || (cmd.scan_step && sts.cur_is_fall), sts.out_free)

endmodule

`default_nettype wire

>>> src/fbec_dp.sv
// ----------------------------------------------------------------------------
// fbec_dp
// Datapath: configuration registers, run state, edge encoder, address
// arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fbec_dp import fbec_pkg::*; #(
	parameter int CHUNK_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] record_start,
	input  wire logic [63:0] record_length,
	input  wire logic [63:0] chunk_bits,
	input  wire logic [6:0]  chunk_bit_count,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [63:0]      extent_base,
	output logic [63:0]      extent_end,
	output logic [1:0]       break_reason,
	output logic             count_mismatch,
	output logic [31:0]      extents_found,
	output logic             last
);

	localparam int IDX_W = (CHUNK_BITS > 1) ? $clog2(CHUNK_BITS) : 1;
	localparam int CNT_W = $clog2(CHUNK_BITS + 1);

	// configuration
	logic [63:0] group_start_q, group_length_q;
	logic [4:0]  shift_q;
	logic [31:0] exp_q;

	// run state
	logic        prev_q;
	logic [63:0] run_start_q, scan_q;
	logic [31:0] ext_cnt_q;

	// latched item
	logic [1:0]            act_q;
	logic [63:0]           rs_q, rl_q;
	logic [CHUNK_BITS-1:0] bits_q;
	logic [CNT_W-1:0]      n_q;

	logic [63:0]           group_end_q, record_end_q;
	logic [CHUNK_BITS-1:0] trans_q;

	// output register
	logic        out_valid_q, kind_q, mism_q, last_q;
	logic [63:0] ostart_q, oend_q;
	logic [1:0]  reason_q;
	logic [31:0] ofound_q;

	logic [CHUNK_BITS-1:0] valid_mask, prev_vec, low_bit;
	logic [IDX_W-1:0]      low_idx, last_idx;
	logic [63:0]           edge_addr;
	logic                  cur_fall, falls_left, out_free;
	logic [31:0]           cnt_inc;
	logic [1:0]            reason;

	always_comb begin
		for (int i = 0; i < CHUNK_BITS; i++) begin
			valid_mask[i] = (CNT_W'(i) < n_q);
		end
	end

	if (CHUNK_BITS > 1) begin : g_prev
		assign prev_vec = {bits_q[CHUNK_BITS-2:0], prev_q};
	end else begin : g_prev1
		assign prev_vec = prev_q;
	end

	// lowest pending edge
	assign low_bit = trans_q & (~trans_q + 1'b1);

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < CHUNK_BITS; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | IDX_W'(i);
			end
		end
	end

	assign edge_addr  = scan_q + (64'(low_idx) << shift_q);
	assign cur_fall   = |(low_bit & ~bits_q);
	assign falls_left = |(trans_q & ~bits_q & ~low_bit);
	assign last_idx   = IDX_W'(n_q - 1'b1);
	assign out_free   = !out_valid_q || out_ready;
	assign cnt_inc    = ext_cnt_q + 32'd1;

	always_comb begin
		priority if (act_q == ACT_END) begin
			reason = RSN_NORMAL;
		end else if (act_q == ACT_FOREIGN) begin
			reason = RSN_FOREIGN;
		end else if (rs_q >= group_end_q) begin
			reason = RSN_START_PAST;
		end else begin
			reason = RSN_END_PAST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_start_q  <= '0;
			group_length_q <= '0;
			shift_q        <= SECTOR_SHIFT_RST;
			exp_q          <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_GROUP_START:  group_start_q  <= cfg_wdata;
				REG_GROUP_LENGTH: group_length_q <= cfg_wdata;
				REG_SECTOR_SHIFT: shift_q        <= cfg_wdata[4:0];
				REG_EXP_EXTENTS:  exp_q          <= cfg_wdata[31:0];
			endcase
		end
	end

	// item latch and working values
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q  <= action;
			rs_q   <= record_start;
			rl_q   <= record_length;
			bits_q <= chunk_bits[CHUNK_BITS-1:0];
			n_q    <= (chunk_bit_count > 7'(CHUNK_BITS)) ? CNT_W'(CHUNK_BITS)
				: CNT_W'(chunk_bit_count);
		end
		if (cmd.prep_group) begin
			group_end_q  <= group_start_q + group_length_q;
			record_end_q <= rs_q + rl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q <= '0;
		end else if (cmd.prep_chunk) begin
			trans_q <= (bits_q ^ prev_vec) & valid_mask;
		end else if (cmd.scan_step) begin
			trans_q <= trans_q & ~low_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b0;
			run_start_q <= '0;
			scan_q      <= '0;
			ext_cnt_q   <= '0;
		end else begin
			if (cmd.scan_step) begin
				if (cur_fall) begin
					ext_cnt_q <= cnt_inc;
				end else begin
					run_start_q <= edge_addr;
				end
			end
			if (cmd.chunk_done) begin
				scan_q <= scan_q + (64'(n_q) << shift_q);
				if (n_q != '0) begin
					prev_q <= bits_q[last_idx];
				end
			end
			if (cmd.hdr_load) begin
				scan_q <= rs_q;
			end
			if (cmd.emit_ext_fin) begin
				ext_cnt_q <= cnt_inc;
			end
			if (cmd.emit_sum) begin
				prev_q      <= 1'b0;
				run_start_q <= '0;
				scan_q      <= '0;
				ext_cnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.scan_step && cur_fall) || cmd.emit_ext_fin || cmd.emit_sum) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && cur_fall) begin
			kind_q   <= KIND_EXTENT;
			ostart_q <= run_start_q;
			oend_q   <= edge_addr;
			reason_q <= RSN_NORMAL;
			mism_q   <= 1'b0;
			ofound_q <= cnt_inc;
			last_q   <= !falls_left;
		end else if (cmd.emit_ext_fin) begin
			kind_q   <= KIND_EXTENT;
			ostart_q <= run_start_q;
			oend_q   <= group_end_q;
			reason_q <= RSN_NORMAL;
			mism_q   <= 1'b0;
			ofound_q <= cnt_inc;
			last_q   <= 1'b0;
		end else if (cmd.emit_sum) begin
			kind_q   <= KIND_SUMMARY;
			ostart_q <= '0;
			oend_q   <= '0;
			reason_q <= reason;
			mism_q   <= (ext_cnt_q != exp_q);
			ofound_q <= ext_cnt_q;
			last_q   <= 1'b1;
		end
	end

	assign sts.act         = act_q;
	assign sts.trans_any   = |trans_q;
	assign sts.cur_is_fall = cur_fall;
	assign sts.start_bad   = (rs_q >= group_end_q);
	assign sts.end_bad     = (record_end_q > group_end_q);
	assign sts.carry_bit   = prev_q;
	assign sts.out_free    = out_free;

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign extent_base    = ostart_q;
	assign extent_end     = oend_q;
	assign break_reason   = reason_q;
	assign count_mismatch = mism_q;
	assign extents_found  = ofound_q;
	assign last           = last_q;

	`FBEC_ASSERT_IMP(a_fin_ext_open, clk, arst_n, cmd.emit_ext_fin, prev_q)
	`FBEC_ASSERT_NEXT(a_rearm, clk, arst_n, cmd.emit_sum, ext_cnt_q == '0 && !prev_q && scan_q == '0 && run_start_q == '0)
	`FBEC_ASSERT_IMP(a_summary_last, clk, arst_n, out_valid_q && kind_q == KIND_SUMMARY, last_q)

endmodule

`default_nettype wire

>>> verif/free_extent_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_extent_monitor
// Watches the register port and both channels of the bitmap extent block,
// works out the extents and group summaries that each input transfer should
// give, and compares every result transfer in order against them.
// ----------------------------------------------------------------------------
module free_extent_monitor import fbec_pkg::*; #(
	parameter int CHUNK_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] record_start,
	input  logic [63:0] record_length,
	input  logic [63:0] chunk_bits,
	input  logic [6:0]  chunk_bit_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [63:0] extent_base,
	input  logic [63:0] extent_end,
	input  logic [1:0]  break_reason,
	input  logic        count_mismatch,
	input  logic [31:0] extents_found,
	input  logic        last,
	output int          mismatches,
	output int          extents_pending
);

	typedef struct packed {
		logic        kind;
		logic [63:0] first;
		logic [63:0] past;
		logic [1:0]  reason;
		logic        mism;
		logic [31:0] found;
		logic        last;
	} extent_rec_t;

	// register copies
	logic [63:0] grp_start;
	logic [63:0] grp_len;
	logic [4:0]  sec_shift;
	logic [31:0] claimed_extents;

	// scan state
	logic        run_open;
	logic [63:0] run_from;
	logic [63:0] scan_addr;
	logic [31:0] extent_tally;

	extent_rec_t extent_queue[$];
	int          errors;

	task automatic clear_scan();
		run_open     = 1'b0;
		run_from     = '0;
		scan_addr    = '0;
		extent_tally = '0;
	endtask

	task automatic queue_result(input logic k, input logic [63:0] first, past,
			input logic [1:0] why, input logic mism);
		extent_rec_t r;
		r.kind   = k;
		r.first  = first;
		r.past   = past;
		r.reason = why;
		r.mism   = mism;
		r.found  = extent_tally;
		r.last   = 1'b0;
		extent_queue.push_back(r);
	endtask

	// an open run is cut at the group end, then the summary and a rearm
	task automatic close_group(input logic [1:0] why, input logic [63:0] grp_end);
		if (run_open) begin
			extent_tally = extent_tally + 32'd1;
			queue_result(KIND_EXTENT, run_from, grp_end, RSN_NORMAL, 1'b0);
		end
		queue_result(KIND_SUMMARY, '0, '0, why, extent_tally != claimed_extents);
		clear_scan();
	endtask

	task automatic predict_extents(input logic [1:0] act, input logic [63:0] rs, rl,
			bits, input logic [6:0] cnt);
		logic [63:0] grp_end;
		logic [63:0] sector_bytes;
		logic        b;
		int          nbits;
		int          queued;
		extent_rec_t tail;
		queued       = extent_queue.size();
		grp_end      = grp_start + grp_len;
		sector_bytes = 64'd1 << sec_shift;
		case (act)
			ACT_HEADER: begin
				if (rs >= grp_end)
					close_group(RSN_START_PAST, grp_end);
				else if (rs + rl > grp_end)
					close_group(RSN_END_PAST, grp_end);
				else
					scan_addr = rs;
			end
			ACT_CHUNK: begin
				nbits = (cnt > CHUNK_BITS) ? CHUNK_BITS : int'(cnt);
				for (int i = 0; i < nbits; i++) begin
					b = bits[i];
					if (!run_open && b) begin
						run_from = scan_addr;
					end else if (run_open && !b) begin
						extent_tally = extent_tally + 32'd1;
						queue_result(KIND_EXTENT, run_from, scan_addr, RSN_NORMAL, 1'b0);
					end
					run_open  = b;
					scan_addr = scan_addr + sector_bytes;
				end
			end
			ACT_END:
				close_group(RSN_NORMAL, grp_end);
			default:
				close_group(RSN_FOREIGN, grp_end);
		endcase
		if (extent_queue.size() > queued) begin
			tail = extent_queue.pop_back();
			tail.last = 1'b1;
			extent_queue.push_back(tail);
		end
	endtask

	function automatic int field_differs(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		extent_rec_t want;
		if (!arst_n) begin
			grp_start       = '0;
			grp_len         = '0;
			sec_shift       = SECTOR_SHIFT_RST;
			claimed_extents = '0;
			clear_scan();
			extent_queue.delete();
			errors = 0;
			mismatches      <= 0;
			extents_pending <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_GROUP_START:  grp_start = cfg_wdata;
					REG_GROUP_LENGTH: grp_len = cfg_wdata;
					REG_SECTOR_SHIFT: sec_shift = cfg_wdata[4:0];
					REG_EXP_EXTENTS:  claimed_extents = cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_extents(action, record_start, record_length, chunk_bits,
					chunk_bit_count);
			if (out_valid && out_ready) begin
				if (extent_queue.size() == 0) begin
					$error("unexpected result: kind %0d start %0h end %0h", kind,
						extent_base, extent_end);
					errors++;
				end else begin
					want = extent_queue.pop_front();
					errors += field_differs("kind", want.kind, kind);
					errors += field_differs("extent_base", want.first, extent_base);
					errors += field_differs("extent_end", want.past, extent_end);
					errors += field_differs("break_reason", want.reason, break_reason);
					errors += field_differs("count_mismatch", want.mism, count_mismatch);
					errors += field_differs("extents_found", want.found, extents_found);
					errors += field_differs("last", want.last, last);
				end
			end
			mismatches      <= errors;
			extents_pending <= extent_queue.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the free-bitmap extent block: directed bitmap
// records at reset and extreme register settings, then random groups of
// header, chunk, end and foreign transfers under random idling on both channels,
// with one long output stall. Checking is left to free_extent_monitor.
// ----------------------------------------------------------------------------
module tb_top;
	import fbec_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 80;
	localparam int HOLD_CYCLES     = 400;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 25;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        cfg_wen         = 1'b0;
	logic [1:0]  cfg_index       = REG_GROUP_START;
	logic [63:0] cfg_wdata       = '0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [1:0]  action          = ACT_HEADER;
	logic [63:0] record_start    = '0;
	logic [63:0] record_length   = '0;
	logic [63:0] chunk_bits      = '0;
	logic [6:0]  chunk_bit_count = '0;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic        kind;
	logic [63:0] extent_base;
	logic [63:0] extent_end;
	logic [1:0]  break_reason;
	logic        count_mismatch;
	logic [31:0] extents_found;
	logic        last;

	int          mismatches;
	int          extents_pending;
	int          cycle_count = 0;
	int          hold_asks   = 0;
	bit          calm        = 1'b0;
	logic [63:0] cur_gend    = '0;

	free_bitmap_to_extents_checker dut (.*);

	free_extent_monitor monitor (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL free_bitmap_to_extents_checker");
			$finish;
		end
	end

	// result side: random back-pressure, or one long hold-off on request
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 34);
			end
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] chunk_pattern();
		case ($urandom_range(4))
			0: return '1;
			1: return '0;
			2: return rnd64() & rnd64() & rnd64();
			3: return rnd64() | rnd64();
			default: return rnd64();
		endcase
	endfunction

	function automatic logic [6:0] chunk_count();
		int          pick;
		logic [6:0]  n;
		pick = $urandom_range(99);
		if (pick < 70)
			n = 7'd64;
		else if (pick < 88)
			n = 7'($urandom_range(1, 63));
		else if (pick < 94)
			n = 7'd0;
		else
			n = 7'($urandom_range(65, 127));
		return n;
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [63:0] rs, rl, bits,
			input logic [6:0] cnt);
		if (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 34);
		end
		in_valid        <= 1'b1;
		action          <= act;
		record_start    <= rs;
		record_length   <= rl;
		chunk_bits      <= bits;
		chunk_bit_count <= cnt;
		do @(posedge clk); while (!in_ready);
	endtask

	// registers only change once the block has drained
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (extents_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_group(input logic [63:0] gs, gl, input logic [4:0] shift,
			input logic [31:0] claimed);
		logic [63:0] junk;
		junk = rnd64();
		cfg_wen   <= 1'b1;
		cfg_index <= REG_GROUP_START;
		cfg_wdata <= gs;
		@(posedge clk);
		cfg_index <= REG_GROUP_LENGTH;
		cfg_wdata <= gl;
		@(posedge clk);
		cfg_index <= REG_SECTOR_SHIFT;
		cfg_wdata <= {junk[63:5], shift};
		@(posedge clk);
		cfg_index <= REG_EXP_EXTENTS;
		cfg_wdata <= {junk[63:32], claimed};
		@(posedge clk);
		cfg_wen  <= 1'b0;
		cur_gend = gs + gl;
	endtask

	// mostly a well-formed record: header inside the group, chunks, a close
	task automatic random_group(inout int sent);
		logic [63:0] span;
		logic [63:0] rl;
		logic [63:0] rs;
		logic [1:0]  act;
		int          chunks;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 75) begin
			rl = rnd64() >> $urandom_range(36, 63);
			if (cur_gend <= rl)
				rl = '0;
			span = cur_gend - rl;
			rs = (span == 0) ? '0 : span - 64'd1 - (rnd64() % span);
			send_item(ACT_HEADER, rs, rl, rnd64(), chunk_count());
			chunks = $urandom_range(1, 6);
			repeat (chunks)
				send_item(ACT_CHUNK, rnd64(), rnd64(), chunk_pattern(), chunk_count());
			pick = $urandom_range(9);
			if (pick < 8)
				send_item(ACT_END, rnd64(), rnd64(), rnd64(), chunk_count());
			else if (pick == 8)
				send_item(ACT_FOREIGN, rnd64(), rnd64(), rnd64(), chunk_count());
			else
				send_item(ACT_HEADER, rnd64(), rnd64(), rnd64(), chunk_count());
			sent += chunks + 2;
		end else begin
			act = 2'($urandom_range(3));
			send_item(act, rnd64(), rnd64(), chunk_pattern(), chunk_count());
			sent += 1;
		end
	endtask

	initial begin : stimulus
		logic [63:0] gs;
		logic [63:0] gl;
		logic [4:0]  shift;
		logic [31:0] claimed;
		int          sent;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: group end is zero, so every header is refused
		send_item(ACT_CHUNK, rnd64(), rnd64(), 64'hFFFF_0000_0000_FFFF, 7'd64);
		send_item(ACT_HEADER, '0, '0, rnd64(), 7'd64);
		send_item(ACT_FOREIGN, rnd64(), rnd64(), rnd64(), 7'd1);
		send_item(ACT_END, rnd64(), rnd64(), rnd64(), 7'd127);
		settle();

		program_group(64'h1000_0000, 64'h0100_0000, 5'd9, 32'd2);
		send_item(ACT_HEADER, 64'h1000_0000, 64'h1000, '0, 7'd0);
		send_item(ACT_CHUNK, '0, '0, '1, 7'd64);
		send_item(ACT_CHUNK, '0, '0, '0, 7'd1);
		send_item(ACT_CHUNK, '0, '0, 64'h5555_5555_5555_5555, 7'd64);
		send_item(ACT_CHUNK, '0, '0, rnd64(), 7'd0);
		send_item(ACT_CHUNK, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA, 7'd127);
		send_item(ACT_CHUNK, '0, '0, '0, 7'd65);
		// record end wraps round below the group end: accepted
		send_item(ACT_HEADER, 64'h10FF_FFFF, '1, '0, 7'd64);
		send_item(ACT_CHUNK, '0, '0, 64'h8000_0000_0000_0000, 7'd64);
		send_item(ACT_HEADER, 64'h10FF_FFFF, 64'd2, '0, 7'd64);
		send_item(ACT_HEADER, 64'h1100_0000, '0, '0, 7'd64);
		send_item(ACT_CHUNK, '0, '0, 64'd1, 7'd1);
		send_item(ACT_FOREIGN, '0, '0, '0, 7'd64);
		settle();

		// group end wraps, largest shift; scan address wraps too
		program_group('1, '1, 5'd31, '1);
		send_item(ACT_HEADER, 64'hFFFF_FFFF_FFFF_FFFD, 64'd1, '0, 7'd64);
		send_item(ACT_CHUNK, '0, '0, 64'h6, 7'd3);
		send_item(ACT_CHUNK, '0, '0, '0, 7'd1);
		send_item(ACT_END, '1, '1, '1, '1);
		settle();

		program_group('0, '1, 5'd0, '0);
		send_item(ACT_HEADER, '0, '1, '1, 7'd64);
		send_item(ACT_CHUNK, '1, '1, rnd64(), 7'd64);
		send_item(ACT_END, '0, '0, '0, 7'd64);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			gs = rnd64() >> $urandom_range(0, 63);
			gl = rnd64() >> $urandom_range(0, 63);
			if ($urandom_range(9) == 0)
				shift = 5'($urandom_range(31));
			else
				shift = 5'($urandom_range(9, 16));
			if ($urandom_range(9) == 0)
				claimed = $urandom;
			else
				claimed = $urandom_range(0, 6);
			program_group(gs, gl, shift, claimed);
			calm = (phase == 5);
			if (phase == 2) begin
				// output held off while dense chunks keep coming
				hold_asks++;
				repeat (16)
					send_item(ACT_CHUNK, rnd64(), rnd64(), 64'h5555_5555_5555_5555, 7'd64);
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE)
				random_group(sent);
			settle();
			calm = 1'b0;
		end

		if (mismatches == 0)
			$display("PASS free_bitmap_to_extents_checker");
		else
			$display("FAIL free_bitmap_to_extents_checker");
		$finish;
	end

endmodule
